// ===== rtl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants for the sine/cosine series block
// Fixed-point constants for angle reduction and the Q60 series datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

    localparam int Q60_W = 64;
    localparam int RED_W = 62;
    localparam int RED_STAGES = 5;

    localparam logic signed [RED_W-1:0] PI_Q52     = 62'sh3243F6A8885A31;
    localparam logic signed [RED_W-1:0] TWO_PI_Q52 = 62'sh6487ED5110B461;
    localparam logic signed [Q60_W-1:0] ONE_Q60    = 64'sh1000000000000000;
    localparam logic [Q60_W-1:0]        MAX_Q60    = 64'h7FFFFFFFFFFFFFFF;
    localparam logic [34:0]             ONE_Q30    = 35'h40000000;

    typedef struct packed {
        logic                     valid;
        logic                     func;
        logic signed [Q60_W-1:0]  x2;
        logic signed [Q60_W-1:0]  term;
        logic signed [Q60_W-1:0]  res;
    } t_cell_bus;

endpackage

`default_nettype wire

// ===== rtl/scs_mul.sv =====
// ----------------------------------------------------------------------------
// scs_mul: three-stage signed Q60 multiplier
// Magnitude product from four 32x32 partials, round to nearest with ties
// away from zero, saturate the magnitude, restore the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_mul #(
    parameter int SIDE_W = 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic signed [scs_pkg::Q60_W-1:0]    i_a,
    input  wire logic signed [scs_pkg::Q60_W-1:0]    i_b,
    input  wire logic [SIDE_W-1:0]                   i_side,
    output logic                                     o_valid,
    output logic signed [scs_pkg::Q60_W-1:0]         o_p,
    output logic [SIDE_W-1:0]                        o_side
);

    logic [63:0]  ua, ub;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic         r_neg1, r_neg2, r_vld1, r_vld2;
    logic [SIDE_W-1:0] r_side1, r_side2;
    logic [127:0] r_prod, n_prod;
    logic [128:0] rnd;
    logic [68:0]  magf;
    logic [63:0]  mag;
    logic signed [63:0] n_p;

    always_comb begin
        ua = i_a[63] ? (64'd0 - i_a) : i_a;
        ub = i_b[63] ? (64'd0 - i_b) : i_b;
        n_prod = {r_p11, 64'd0} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
               + {64'd0, r_p00};
        rnd  = {1'b0, r_prod} + (129'd1 << 59);
        magf = rnd[128:60];
        mag  = (|magf[68:63]) ? scs_pkg::MAX_Q60 : magf[63:0];
        n_p  = r_neg2 ? $signed(64'd0 - mag) : $signed(mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1  <= 1'b0;
            r_vld2  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_vld1  <= i_valid;
            r_vld2  <= r_vld1;
            o_valid <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p00   <= ua[31:0]  * ub[31:0];
        r_p01   <= ua[31:0]  * ub[63:32];
        r_p10   <= ua[63:32] * ub[31:0];
        r_p11   <= ua[63:32] * ub[63:32];
        r_neg1  <= i_a[63] ^ i_b[63];
        r_side1 <= i_side;
        r_prod  <= n_prod;
        r_neg2  <= r_neg1;
        r_side2 <= r_side1;
        o_p     <= n_p;
        o_side  <= r_side2;
    end

endmodule

`default_nettype wire

// ===== rtl/scs_reduce.sv =====
// ----------------------------------------------------------------------------
// scs_reduce: angle reduction into [-pi, pi]
// Widen Q8.24 to Q52, then remove binary-weighted multiples of 2*pi, one
// weight per stage, and hand out the reduced angle in Q60.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_reduce (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic                              i_func,
    input  wire logic signed [31:0]                i_angle,
    output logic                                   o_valid,
    output logic                                   o_func,
    output logic signed [scs_pkg::Q60_W-1:0]       o_x
);

    localparam int NS = scs_pkg::RED_STAGES;

    logic                              r_vld  [0:NS];
    logic                              r_func [0:NS];
    logic                              r_neg  [0:NS];
    logic signed [scs_pkg::RED_W-1:0]  r_x    [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func[0] <= i_func;
        r_neg[0]  <= i_angle[31];
        r_x[0]    <= {{2{i_angle[31]}}, i_angle, 28'd0};
    end

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam logic signed [scs_pkg::RED_W-1:0] STEP =
            scs_pkg::TWO_PI_Q52 <<< (NS - 1 - j);
        logic signed [scs_pkg::RED_W-1:0] sub, add, n_x;

        always_comb begin
            sub = r_x[j] - STEP;
            add = r_x[j] + STEP;
            if (r_neg[j]) begin
                n_x = (add < scs_pkg::PI_Q52) ? add : r_x[j];
            end else begin
                n_x = (sub > -scs_pkg::PI_Q52) ? sub : r_x[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_func[j+1] <= r_func[j];
            r_neg[j+1]  <= r_neg[j];
            r_x[j+1]    <= n_x;
        end
    end

    assign o_valid = r_vld[NS];
    assign o_func  = r_func[NS];
    assign o_x     = {r_x[NS][55:0], 8'd0};

endmodule

`default_nettype wire

// ===== rtl/scs_cell.sv =====
// ----------------------------------------------------------------------------
// scs_cell: one Taylor series term
// Form the step factor x^2/((i-1)*i), scale the running term by it and
// fold the new term into the running sum with alternating sign.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_cell #(
    parameter int IDX = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire scs_pkg::t_cell_bus    i_bus,
    output scs_pkg::t_cell_bus         o_bus
);

    localparam longint unsigned D_SIN = longint'((2*IDX+2) * (2*IDX+3));
    localparam longint unsigned D_COS = longint'((2*IDX+1) * (2*IDX+2));
    localparam longint unsigned R_SIN = ((64'd1 << 60) + D_SIN / 2) / D_SIN;
    localparam longint unsigned R_COS = ((64'd1 << 60) + D_COS / 2) / D_COS;
    localparam bit SUB = ((IDX % 2) == 0);

    typedef struct packed {
        logic                                func;
        logic signed [scs_pkg::Q60_W-1:0]    x2;
        logic signed [scs_pkg::Q60_W-1:0]    term;
        logic signed [scs_pkg::Q60_W-1:0]    res;
    } t_side1;

    typedef struct packed {
        logic                                func;
        logic signed [scs_pkg::Q60_W-1:0]    x2;
        logic signed [scs_pkg::Q60_W-1:0]    res;
    } t_side2;

    t_side1 side1_in, side1_out;
    t_side2 side2_in, side2_out;
    logic                               vld1, vld2;
    logic signed [scs_pkg::Q60_W-1:0]   recip, factor, term_new;
    scs_pkg::t_cell_bus                 n_bus;

    assign recip    = i_bus.func ? $signed(64'(R_COS)) : $signed(64'(R_SIN));
    assign side1_in = '{func: i_bus.func, x2: i_bus.x2, term: i_bus.term, res: i_bus.res};

    scs_mul #(.SIDE_W($bits(t_side1))) u_fac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_bus.valid),
        .i_a     (i_bus.x2),
        .i_b     (recip),
        .i_side  (side1_in),
        .o_valid (vld1),
        .o_p     (factor),
        .o_side  (side1_out)
    );

    assign side2_in = '{func: side1_out.func, x2: side1_out.x2, res: side1_out.res};

    scs_mul #(.SIDE_W($bits(t_side2))) u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld1),
        .i_a     (side1_out.term),
        .i_b     (factor),
        .i_side  (side2_in),
        .o_valid (vld2),
        .o_p     (term_new),
        .o_side  (side2_out)
    );

    always_comb begin
        n_bus.valid = vld2;
        n_bus.func  = side2_out.func;
        n_bus.x2    = side2_out.x2;
        n_bus.term  = term_new;
        n_bus.res   = SUB ? (side2_out.res - term_new) : (side2_out.res + term_new);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_bus.valid <= 1'b0;
        end else begin
            o_bus.valid <= n_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_bus.func <= n_bus.func;
        o_bus.x2   <= n_bus.x2;
        o_bus.term <= n_bus.term;
        o_bus.res  <= n_bus.res;
    end

endmodule

`default_nettype wire

// ===== rtl/sine_cosine_series_top.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_series_top: fixed-point sine/cosine by Taylor series
// Usage:
//   Drive i_func (0 sine, 1 cosine) and i_angle (signed Q8.24 radians) with
//   start high; the transaction is taken at the clock edge where start is
//   high and busy is low. busy is always low, so a new transaction can be
//   issued in every cycle.
//   The result appears on o_value (signed Q2.30, limited to +/-1.0) for one
//   cycle with o_valid high. The receiver cannot stall, and none is needed:
//   the pipeline never waits.
//   The pipeline runs through angle reduction, the x^2 multiplier, one cell
//   per series term (two three-stage multipliers plus the sum register) and
//   a final rounding register.
//   Throughput is one transaction per cycle, set by the fully pipelined
//   multipliers in the chain of cells.
//   Reset clears all valid flags; transactions in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_cosine_series_top #(
    parameter int SERIES_TERMS = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_func,
    input  wire logic signed [31:0]  i_angle,
    output logic                     o_valid,
    output logic signed [31:0]       o_value
);

    logic                              red_vld, red_func, sq_vld;
    logic signed [scs_pkg::Q60_W-1:0]  red_x, x2;
    logic [scs_pkg::Q60_W:0]           sq_side;
    scs_pkg::t_cell_bus                chain [0:SERIES_TERMS];
    scs_pkg::t_cell_bus                last;
    logic [scs_pkg::Q60_W-1:0]         mag;
    logic [scs_pkg::Q60_W:0]           rsum;
    logic [34:0]                       m;
    logic [31:0]                       m32;
    logic signed [31:0]                n_value;
    logic                              sq_func;
    logic signed [scs_pkg::Q60_W-1:0]  sq_x;

    assign busy = 1'b0;

    scs_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_func  (i_func),
        .i_angle (i_angle),
        .o_valid (red_vld),
        .o_func  (red_func),
        .o_x     (red_x)
    );

    scs_mul #(.SIDE_W(scs_pkg::Q60_W + 1)) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (red_vld),
        .i_a     (red_x),
        .i_b     (red_x),
        .i_side  ({red_func, red_x}),
        .o_valid (sq_vld),
        .o_p     (x2),
        .o_side  (sq_side)
    );

    assign sq_func = sq_side[scs_pkg::Q60_W];
    assign sq_x    = sq_side[scs_pkg::Q60_W-1:0];

    always_comb begin
        chain[0].valid = sq_vld;
        chain[0].func  = sq_func;
        chain[0].x2    = x2;
        chain[0].term  = sq_func ? scs_pkg::ONE_Q60 : sq_x;
        chain[0].res   = sq_func ? scs_pkg::ONE_Q60 : sq_x;
    end

    for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_cell
        scs_cell #(.IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (chain[k]),
            .o_bus   (chain[k+1])
        );
    end

    always_comb begin
        last    = chain[SERIES_TERMS];
        mag     = last.res[63] ? (64'd0 - last.res) : last.res;
        rsum    = {1'b0, mag} + (65'd1 << 29);
        m       = rsum[64:30];
        m32     = (m > scs_pkg::ONE_Q30) ? scs_pkg::ONE_Q30[31:0] : m[31:0];
        n_value = last.res[63] ? $signed(32'd0 - m32) : $signed(m32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_value <= n_value;
    end

endmodule

`default_nettype wire

// ===== rtl/scs_checker.sv =====
// ----------------------------------------------------------------------------
// scs_checker: port-level checks for the sine/cosine series block
// Result range, result timing against issued transactions and exact values
// at a zero angle.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_checker #(
    parameter int LATENCY = 80
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic                i_func,
    input  wire logic signed [31:0]  i_angle,
    input  wire logic                o_valid,
    input  wire logic signed [31:0]  o_value
);

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value <= 32'sh40000000) && (o_value >= -32'sh40000000))
        else $error("result outside +/-1.0");

    a_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transaction");

    a_sin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(start, LATENCY) && ($past(i_func, LATENCY) == 1'b0)
         && ($past(i_angle, LATENCY) == 32'sd0)) |-> (o_value == 32'sd0))
        else $error("sine of zero is not zero");

    a_cos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(start, LATENCY) && ($past(i_func, LATENCY) == 1'b1)
         && ($past(i_angle, LATENCY) == 32'sd0)) |-> (o_value == 32'sh40000000))
        else $error("cosine of zero is not one");

endmodule

bind sine_cosine_series_top scs_checker #(.LATENCY(7 * SERIES_TERMS + 10)) u_scs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_func  (i_func),
    .i_angle (i_angle),
    .o_valid (o_valid),
    .o_value (o_value)
);

`default_nettype wire

// ===== sim/sine_cosine_series_checker.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_series_checker: result predictor and comparator
// Watches the command and result channels, computes the expected Q2.30
// sine or cosine of each accepted angle, and compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_cosine_series_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic               i_func,
    input  wire logic signed [31:0] i_angle,
    input  wire logic               o_valid,
    input  wire logic signed [31:0] o_value,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_seen
);

    localparam int TERMS = 10;

    logic signed [31:0] value_q[$];

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic [127:0] prod;
        logic [127:0] rnd;
        logic [63:0]  mag;
        logic         neg;
        neg  = (a < 0) != (b < 0);
        prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        rnd  = (prod + (128'd1 << 59)) >> 60;
        if (rnd > {64'd0, scs_pkg::MAX_Q60}) mag = scs_pkg::MAX_Q60;
        else mag = rnd[63:0];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [63:0] recip(input longint d);
        return ((longint'(1) << 60) + d / 2) / d;
    endfunction

    function automatic logic signed [31:0] series_value(input logic f,
                                                        input logic signed [31:0] ang);
        logic signed [63:0] x;
        logic signed [63:0] x2;
        logic signed [63:0] term;
        logic signed [63:0] acc;
        logic [63:0]        m;
        longint             i;
        x = longint'(ang) * (longint'(1) << 28);
        while (x > longint'(scs_pkg::PI_Q52)) x -= longint'(scs_pkg::TWO_PI_Q52);
        while (x < -longint'(scs_pkg::PI_Q52)) x += longint'(scs_pkg::TWO_PI_Q52);
        x = x * 256;
        x2 = qmul(x, x);
        term = f ? scs_pkg::ONE_Q60 : x;
        acc  = term;
        for (int k = 0; k < TERMS; k++) begin
            i = (f ? 2 : 3) + 2 * k;
            term = qmul(term, qmul(x2, recip((i - 1) * i)));
            if ((k & 1) == 0) acc -= term;
            else acc += term;
        end
        m = (magnitude(acc) + (64'd1 << 29)) >> 30;
        if (m > 64'(scs_pkg::ONE_Q30)) m = 64'(scs_pkg::ONE_Q30);
        return acc < 0 ? -$signed(m[31:0]) : $signed(m[31:0]);
    endfunction

    initial begin
        o_fail_count = 0;
        o_seen = 0;
    end

    assign o_pending = value_q.size();

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) value_q.push_back(series_value(i_func, i_angle));
        if (i_rst_n && o_valid) begin
            o_seen <= o_seen + 1;
            if (value_q.size() == 0) begin
                $error("unexpected result value=%0d", o_value);
                o_fail_count <= o_fail_count + 1;
            end else if (value_q[0] !== o_value) begin
                $error("field value: expected %0d actual %0d", value_q[0], o_value);
                o_fail_count <= o_fail_count + 1;
                void'(value_q.pop_front());
            end else begin
                void'(value_q.pop_front());
            end
        end
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the sine/cosine series block
// Drives directed and random angle transactions in bursts, leaves the
// prediction and comparison to the checker, and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int LATENCY = 80;
    localparam int RANDOM_ITEMS = 1300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               i_func = 1'b0;
    logic signed [31:0] i_angle = '0;
    logic               busy;
    logic               o_valid;
    logic signed [31:0] o_value;
    int                 fail_count;
    int                 pending;
    int                 seen;
    int                 sent;

    always #6 i_clk = ~i_clk;

    sine_cosine_series_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_angle(i_angle), .o_valid(o_valid), .o_value(o_value)
    );

    sine_cosine_series_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_angle(i_angle), .o_valid(o_valid), .o_value(o_value),
        .o_fail_count(fail_count), .o_pending(pending), .o_seen(seen)
    );

    task automatic issue(input logic f, input logic signed [31:0] a);
        @(negedge i_clk);
        start   <= 1'b1;
        i_func  <= f;
        i_angle <= a;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    task automatic pause(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return $signed($urandom());
            1: return $signed(32'($urandom_range(0, 32'h0700_0000))) - 32'sh0380_0000;
            2: return 32'sh0324_3F6A + $signed(32'($urandom_range(0, 8))) - 4;
            3: return -32'sh0324_3F6A + $signed(32'($urandom_range(0, 8))) - 4;
            4: return $signed(32'($urandom_range(0, 2048))) - 1024;
            default: return $signed(32'($urandom_range(0, 32'h0400_0000))) - 32'sh0200_0000;
        endcase
    endfunction

    logic signed [31:0] directed[$] = '{
        32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0324_3F6A, -32'sh0324_3F6A,
        32'sh0324_3F6B, -32'sh0324_3F6B, 32'sh0648_7ED5, 32'sh0192_1FB5, -32'sh0192_1FB5,
        32'sh0000_0001, -32'sh0000_0001, 32'sh0100_0000};

    initial begin
        int burst;
        sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[j]) begin
            issue(1'b0, directed[j]);
            issue(1'b1, directed[j]);
        end
        pause(3);
        while (sent < 26 + RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) issue(1'($urandom_range(0, 1)), pick_angle());
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
        end
        pause(1);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        $display("covered %0d transactions, %0d results checked", sent, seen);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/scs_pkg.sv
rtl/scs_mul.sv
rtl/scs_reduce.sv
rtl/scs_cell.sv
rtl/sine_cosine_series_top.sv
rtl/scs_checker.sv
sim/sine_cosine_series_checker.sv
sim/testbench.sv
